// ===== hdl/tscd_pkg.sv =====
// Shared constants, types and divide-step functions for the timestamp to date pipeline.
package tscd_pkg;

   // Field widths of the request and response beats.
   localparam int TS_W     = 42;
   localparam int YEAR_W   = 12;
   localparam int MONTH_W  = 4;
   localparam int DAY_W    = 5;
   localparam int HOUR_W   = 5;
   localparam int MINUTE_W = 6;
   localparam int SECOND_W = 6;
   localparam int MSEC_W   = 10;

   // Width of the whole-second count and of the day count.
   localparam int SECS_W = 33;
   localparam int DAYS_W = 17;

   // Divisors and limits.
   localparam logic [10:0]        MS_PER_SEC    = 11'd1000;
   localparam logic [17:0]        SEC_PER_DAY   = 18'd86400;
   localparam logic [16:0]        SEC_PER_HOUR  = 17'd3600;
   localparam logic [11:0]        SEC_PER_MIN   = 12'd60;
   localparam logic [16:0]        DAYS_PER_QUAD = 17'd1461;
   localparam logic [YEAR_W-1:0]  EPOCH_YEAR    = 12'd1970;
   localparam logic [SECS_W-1:0]  LIMIT_SECS    = 33'd4102444800;

   // First day of the second, third and fourth year of a four-year cycle that
   // starts at 1970. The third year of the cycle is the leap year.
   localparam logic [10:0] YEAR1_START = 11'd365;
   localparam logic [10:0] YEAR2_START = 11'd730;
   localparam logic [10:0] YEAR3_START = 11'd1096;

   // Day of year on which each month starts.
   localparam logic [8:0] CUM_COMMON [0:11] = '{
      9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};
   localparam logic [8:0] CUM_LEAP [0:11] = '{
      9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
      9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335};

   // Partial state of the millisecond to second long division.
   typedef struct packed {
      logic [MSEC_W-1:0] rem;
      logic [SECS_W-1:0] work;
   } ms_div_type;

   // Partial state of the second to day long division.
   typedef struct packed {
      logic [DAYS_W-1:0] rem;
      logic [DAYS_W-1:0] work;
   } day_div_type;

   // Up to seven restoring steps of division by 1000. Dividend bits leave the
   // top of the work word and quotient bits enter at its bottom.
   function automatic ms_div_type ms_div_steps(input ms_div_type s, input int unsigned n);
      ms_div_type  t;
      logic [10:0] r;
      logic        ge;
      t = s;
      for (int k = 0; k < 7; k++) begin
         if (k < n) begin
            r  = {t.rem, t.work[SECS_W-1]};
            ge = (r >= MS_PER_SEC);
            if (ge) begin
               r = r - MS_PER_SEC;
            end
            t.rem  = r[MSEC_W-1:0];
            t.work = {t.work[SECS_W-2:0], ge};
         end
      end
      return t;
   endfunction

   // Up to six restoring steps of division by 86400.
   function automatic day_div_type day_div_steps(input day_div_type s, input int unsigned n);
      day_div_type t;
      logic [17:0] r;
      logic        ge;
      t = s;
      for (int k = 0; k < 6; k++) begin
         if (k < n) begin
            r  = {t.rem, t.work[DAYS_W-1]};
            ge = (r >= SEC_PER_DAY);
            if (ge) begin
               r = r - SEC_PER_DAY;
            end
            t.rem  = r[DAYS_W-1:0];
            t.work = {t.work[DAYS_W-2:0], ge};
         end
      end
      return t;
   endfunction

endpackage

// ===== hdl/timestamp_to_calendar_date.sv =====
// Pipelined conversion of a millisecond timestamp into calendar date and time of day.
//
//   Channel  Ports                          Direction  Beat
//   req      req_valid, req_stall, req_*    in         one timestamp in milliseconds
//   rsp      rsp_valid, rsp_stall, rsp_*    out        year, month, day, time, overflow flag
//
// The pipeline has eleven register stages. One beat can be taken in every cycle in
// which the pipeline is not frozen, that is while req_stall is low.
// Stages one to five divide by 1000, six to eight divide by 86400, nine and ten split
// the time of day and the four-year cycle, and eleven finds the month and day.
// Reset clears the valid bits of all stages. A stall on rsp while the output stage
// holds a beat freezes the whole pipeline and is passed back to req_stall in the same
// cycle, so no beat is lost or repeated.
module timestamp_to_calendar_date (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tscd_pkg::TS_W-1:0]     req_timestamp_ms,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tscd_pkg::YEAR_W-1:0]   rsp_year,
   output logic [tscd_pkg::MONTH_W-1:0]  rsp_month,
   output logic [tscd_pkg::DAY_W-1:0]    rsp_day,
   output logic [tscd_pkg::HOUR_W-1:0]   rsp_hour,
   output logic [tscd_pkg::MINUTE_W-1:0] rsp_minute,
   output logic [tscd_pkg::SECOND_W-1:0] rsp_second,
   output logic [tscd_pkg::MSEC_W-1:0]   rsp_millisecond,
   output logic                          rsp_beyond_2099
);
   import tscd_pkg::*;

   // Pipeline control: everything moves when the output stage is free or drained.
   logic        adv;
   logic [11:1] valid_ff;

   // Division by 1000.
   ms_div_type  ms_init;
   ms_div_type  ms_in [1:5];
   ms_div_type  ms_ff [1:5];

   // Division by 86400.
   day_div_type day_init;
   day_div_type day_in [6:8];
   day_div_type day_ff [6:8];
   logic        beyond_in;

   // Values carried along the later stages.
   logic [MSEC_W-1:0] msec_ff   [6:11];
   logic              beyond_ff [6:11];

   // Stage nine: hour and four-year cycle.
   logic [HOUR_W-1:0] s9_hour_in, s9_hour_ff;
   logic [11:0]       s9_hrem_in, s9_hrem_ff;
   logic [5:0]        s9_quad_in, s9_quad_ff;
   logic [10:0]       s9_drem_in, s9_drem_ff;

   // Stage ten: minute, second, year and day of year.
   logic [HOUR_W-1:0]   s10_hour_ff;
   logic [MINUTE_W-1:0] s10_minute_in, s10_minute_ff;
   logic [SECOND_W-1:0] s10_second_in, s10_second_ff;
   logic [YEAR_W-1:0]   s10_year_in, s10_year_ff;
   logic [8:0]          s10_doy_in, s10_doy_ff;
   logic                s10_leap_in, s10_leap_ff;

   // Stage eleven: the output register.
   logic [YEAR_W-1:0]   s11_year_ff;
   logic [MONTH_W-1:0]  s11_month_in, s11_month_ff;
   logic [DAY_W-1:0]    s11_day_in, s11_day_ff;
   logic [HOUR_W-1:0]   s11_hour_ff;
   logic [MINUTE_W-1:0] s11_minute_ff;
   logic [SECOND_W-1:0] s11_second_ff;

   assign adv       = !valid_ff[11] || !rsp_stall;
   assign req_stall = !adv;

   // Valid bits follow their beats down the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= {valid_ff[10:1], req_valid};
      end
   end

   // Stages one to five: 33 quotient steps of the division by 1000. The top nine
   // bits are already below 1000 and seed the remainder.
   always_comb begin
      ms_init.rem  = {1'b0, req_timestamp_ms[TS_W-1:SECS_W]};
      ms_init.work = req_timestamp_ms[SECS_W-1:0];
      ms_in[1]     = ms_div_steps(ms_init, 7);
      ms_in[2]     = ms_div_steps(ms_ff[1], 7);
      ms_in[3]     = ms_div_steps(ms_ff[2], 7);
      ms_in[4]     = ms_div_steps(ms_ff[3], 6);
      ms_in[5]     = ms_div_steps(ms_ff[4], 6);
   end

   // Stages six to eight: 17 quotient steps of the division by 86400, and the
   // check for dates in 2100 or later.
   always_comb begin
      day_init.rem  = {1'b0, ms_ff[5].work[SECS_W-1:DAYS_W]};
      day_init.work = ms_ff[5].work[DAYS_W-1:0];
      day_in[6]     = day_div_steps(day_init, 6);
      day_in[7]     = day_div_steps(day_ff[6], 6);
      day_in[8]     = day_div_steps(day_ff[7], 5);
      beyond_in     = (ms_ff[5].work >= LIMIT_SECS);
   end

   // Stage nine: hour from the second of day, cycle count from the day count.
   always_comb begin
      logic [16:0] r;
      logic [16:0] d;
      r = day_ff[8].rem;
      for (int k = HOUR_W - 1; k >= 0; k--) begin
         d = SEC_PER_HOUR << k;
         s9_hour_in[k] = (r >= d);
         if (r >= d) begin
            r = r - d;
         end
      end
      s9_hrem_in = r[11:0];

      r = day_ff[8].work;
      for (int k = 5; k >= 0; k--) begin
         d = DAYS_PER_QUAD << k;
         s9_quad_in[k] = (r >= d);
         if (r >= d) begin
            r = r - d;
         end
      end
      s9_drem_in = r[10:0];
   end

   // Stage ten: minute and second, then the year inside the four-year cycle.
   always_comb begin
      logic [11:0] r;
      logic [11:0] d;
      logic [1:0]  yi;
      r = s9_hrem_ff;
      for (int k = MINUTE_W - 1; k >= 0; k--) begin
         d = SEC_PER_MIN << k;
         s10_minute_in[k] = (r >= d);
         if (r >= d) begin
            r = r - d;
         end
      end
      s10_second_in = r[SECOND_W-1:0];

      if (s9_drem_ff >= YEAR3_START) begin
         yi         = 2'd3;
         s10_doy_in = 9'(s9_drem_ff - YEAR3_START);
      end else if (s9_drem_ff >= YEAR2_START) begin
         yi         = 2'd2;
         s10_doy_in = 9'(s9_drem_ff - YEAR2_START);
      end else if (s9_drem_ff >= YEAR1_START) begin
         yi         = 2'd1;
         s10_doy_in = 9'(s9_drem_ff - YEAR1_START);
      end else begin
         yi         = 2'd0;
         s10_doy_in = s9_drem_ff[8:0];
      end
      s10_leap_in = (yi == 2'd2);
      s10_year_in = EPOCH_YEAR + YEAR_W'({s9_quad_ff, 2'b00}) + YEAR_W'(yi);
   end

   // Stage eleven: month by comparing against every month start, then the day.
   always_comb begin
      logic [8:0] c;
      logic [8:0] base;
      logic [8:0] diff;
      base         = '0;
      s11_month_in = MONTH_W'(1);
      for (int i = 1; i < 12; i++) begin
         c = s10_leap_ff ? CUM_LEAP[i] : CUM_COMMON[i];
         if (s10_doy_ff >= c) begin
            s11_month_in = MONTH_W'(i + 1);
            base         = c;
         end
      end
      diff       = s10_doy_ff - base;
      s11_day_in = DAY_W'(diff + 9'd1);
   end

   // Stage registers hold while the pipeline is frozen.
   always_ff @(posedge clock) begin
      if (adv) begin
         ms_ff  <= ms_in;
         day_ff <= day_in;

         msec_ff[6]   <= ms_ff[5].rem;
         beyond_ff[6] <= beyond_in;
         for (int i = 7; i <= 11; i++) begin
            msec_ff[i]   <= msec_ff[i-1];
            beyond_ff[i] <= beyond_ff[i-1];
         end

         s9_hour_ff <= s9_hour_in;
         s9_hrem_ff <= s9_hrem_in;
         s9_quad_ff <= s9_quad_in;
         s9_drem_ff <= s9_drem_in;

         s10_hour_ff   <= s9_hour_ff;
         s10_minute_ff <= s10_minute_in;
         s10_second_ff <= s10_second_in;
         s10_year_ff   <= s10_year_in;
         s10_doy_ff    <= s10_doy_in;
         s10_leap_ff   <= s10_leap_in;

         s11_year_ff   <= s10_year_ff;
         s11_month_ff  <= s11_month_in;
         s11_day_ff    <= s11_day_in;
         s11_hour_ff   <= s10_hour_ff;
         s11_minute_ff <= s10_minute_ff;
         s11_second_ff <= s10_second_ff;
      end
   end

   // Response beat comes straight from the last stage.
   assign rsp_valid       = valid_ff[11];
   assign rsp_year        = s11_year_ff;
   assign rsp_month       = s11_month_ff;
   assign rsp_day         = s11_day_ff;
   assign rsp_hour        = s11_hour_ff;
   assign rsp_minute      = s11_minute_ff;
   assign rsp_second      = s11_second_ff;
   assign rsp_millisecond = msec_ff[11];
   assign rsp_beyond_2099 = beyond_ff[11];

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the millisecond timestamp to calendar date pipeline.
module tb;
   import tscd_pkg::*;

   localparam longint unsigned TS_MAX       = (64'd1 << TS_W) - 64'd1;
   localparam longint unsigned MS_AT_2100   = 64'd4102444800000;
   localparam int              RANDOM_ITEMS = 500;
   localparam int              DRAIN_CYCLES = 30;

   // One calendar result as it leaves the block.
   typedef struct packed {
      logic [YEAR_W-1:0]   year;
      logic [MONTH_W-1:0]  month;
      logic [DAY_W-1:0]    day;
      logic [HOUR_W-1:0]   hour;
      logic [MINUTE_W-1:0] minute;
      logic [SECOND_W-1:0] second;
      logic [MSEC_W-1:0]   millisecond;
      logic                beyond_2099;
   } calendar_date_type;

   // Predicts the date of every accepted timestamp and checks results in order.
   class date_scoreboard_type;
      calendar_date_type expected_dates[$];
      int unsigned       failures;

      function new();
         failures = 0;
      endfunction

      // Length of a year in seconds under the four-year leap rule.
      static function longint unsigned year_secs(int unsigned yr);
         return (yr % 4 == 0) ? 64'd31622400 : 64'd31536000;
      endfunction

      // Number of days in the year that come before month mon (1 is January).
      static function int unsigned days_before(bit leap, int unsigned mon);
         int unsigned days;
         case (mon)
            1:       days = 0;
            2:       days = 31;
            3:       days = 59;
            4:       days = 90;
            5:       days = 120;
            6:       days = 151;
            7:       days = 181;
            8:       days = 212;
            9:       days = 243;
            10:      days = 273;
            11:      days = 304;
            default: days = 334;
         endcase
         if (leap && mon >= 3) begin
            days = days + 1;
         end
         return days;
      endfunction

      function calendar_date_type to_calendar(logic [TS_W-1:0] ts);
         calendar_date_type d;
         longint unsigned   secs;
         longint unsigned   ms_part;
         int unsigned       yr;
         int unsigned       mon;
         bit                leap;
         secs    = longint'(ts) / 1000;
         ms_part = longint'(ts) % 1000;
         yr      = 1970;
         // Peel off whole years.
         while (secs >= year_secs(yr)) begin
            secs = secs - year_secs(yr);
            yr++;
         end
         leap = (yr % 4 == 0);
         // Find the month whose start is the last one not after the second count.
         mon = 1;
         while (mon < 12 && longint'(days_before(leap, mon + 1)) * 86400 <= secs) begin
            mon++;
         end
         secs = secs - longint'(days_before(leap, mon)) * 86400;
         d.year        = yr[YEAR_W-1:0];
         d.month       = mon[MONTH_W-1:0];
         d.day         = DAY_W'(secs / 86400 + 1);
         d.hour        = HOUR_W'((secs % 86400) / 3600);
         d.minute      = MINUTE_W'((secs % 3600) / 60);
         d.second      = SECOND_W'(secs % 60);
         d.millisecond = MSEC_W'(ms_part);
         d.beyond_2099 = (yr >= 2100);
         return d;
      endfunction

      task report(string what);
         $display("mismatch at %0t: %s", $time, what);
         failures++;
      endtask

      function void note_timestamp(logic [TS_W-1:0] ts);
         expected_dates.push_back(to_calendar(ts));
      endfunction

      task check_date(calendar_date_type got);
         calendar_date_type want;
         if (expected_dates.size() == 0) begin
            report($sformatf("result %0d-%0d-%0d with no timestamp pending",
                             got.year, got.month, got.day));
         end else begin
            want = expected_dates.pop_front();
            if (got.year !== want.year)
               report($sformatf("year got %0d expected %0d", got.year, want.year));
            if (got.month !== want.month)
               report($sformatf("month got %0d expected %0d", got.month, want.month));
            if (got.day !== want.day)
               report($sformatf("day got %0d expected %0d", got.day, want.day));
            if (got.hour !== want.hour)
               report($sformatf("hour got %0d expected %0d", got.hour, want.hour));
            if (got.minute !== want.minute)
               report($sformatf("minute got %0d expected %0d", got.minute, want.minute));
            if (got.second !== want.second)
               report($sformatf("second got %0d expected %0d", got.second, want.second));
            if (got.millisecond !== want.millisecond)
               report($sformatf("millisecond got %0d expected %0d",
                                got.millisecond, want.millisecond));
            if (got.beyond_2099 !== want.beyond_2099)
               report($sformatf("beyond_2099 got %0b expected %0b",
                                got.beyond_2099, want.beyond_2099));
         end
      endtask

      function int unsigned pending();
         return expected_dates.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [TS_W-1:0]     req_timestamp_ms = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [YEAR_W-1:0]   rsp_year;
   logic [MONTH_W-1:0]  rsp_month;
   logic [DAY_W-1:0]    rsp_day;
   logic [HOUR_W-1:0]   rsp_hour;
   logic [MINUTE_W-1:0] rsp_minute;
   logic [SECOND_W-1:0] rsp_second;
   logic [MSEC_W-1:0]   rsp_millisecond;
   logic                rsp_beyond_2099;

   date_scoreboard_type sb;
   bit                  calm = 1'b0;

   timestamp_to_calendar_date i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_timestamp_ms (req_timestamp_ms),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_year         (rsp_year),
      .rsp_month        (rsp_month),
      .rsp_day          (rsp_day),
      .rsp_hour         (rsp_hour),
      .rsp_minute       (rsp_minute),
      .rsp_second       (rsp_second),
      .rsp_millisecond  (rsp_millisecond),
      .rsp_beyond_2099  (rsp_beyond_2099)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Idle cycles before the next beat; none at all during calm stretches.
   function automatic int draw_pause();
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   // Millisecond count at midnight starting the given day of the given month.
   function automatic longint unsigned day_start_ms(int unsigned yr, int unsigned mon,
                                                    int unsigned dy);
      longint unsigned secs;
      secs = 0;
      for (int unsigned y = 1970; y < yr; y++) begin
         secs = secs + date_scoreboard_type::year_secs(y);
      end
      secs = secs + longint'(date_scoreboard_type::days_before(yr % 4 == 0, mon) + dy - 1)
             * 86400;
      return secs * 1000;
   endfunction

   task automatic send_timestamp(input longint unsigned ts);
      int pause;
      pause = draw_pause();
      if (pause > 0) begin
         req_valid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_timestamp_ms <= ts[TS_W-1:0];
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   // Random timestamp: full range, the reliable range, or close to a month start.
   function automatic longint unsigned random_timestamp();
      longint unsigned ts;
      longint unsigned raw;
      int unsigned     pick;
      raw  = {$urandom, $urandom};
      pick = $urandom_range(0, 9);
      if (pick <= 2) begin
         ts = raw & TS_MAX;
      end else if (pick <= 5) begin
         ts = raw % (MS_AT_2100 + 64'd1000000);
      end else begin
         ts = day_start_ms($urandom_range(1970, 2109), $urandom_range(1, 12), 1);
         if ($urandom_range(0, 1) == 0) begin
            ts = ts + $urandom_range(0, 86399999);
         end else if (ts >= 2000) begin
            ts = ts + $urandom_range(0, 4000) - 2000;
         end
         if (ts > TS_MAX) begin
            ts = TS_MAX - $urandom_range(0, 999);
         end
      end
      return ts;
   endfunction

   // Result side: stall for a drawn number of cycles, then take one beat.
   initial begin
      int pause;
      forever begin
         pause = draw_pause();
         if (pause > 0) begin
            rsp_stall <= 1'b1;
            repeat (pause) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Watch both channels and hand every accepted beat to the scoreboard.
   always @(posedge clock) begin
      calendar_date_type got;
      if (!reset) begin
         if (req_valid === 1'b1 && req_stall === 1'b0) begin
            sb.note_timestamp(req_timestamp_ms);
         end
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            got = '{rsp_year, rsp_month, rsp_day, rsp_hour, rsp_minute, rsp_second,
                    rsp_millisecond, rsp_beyond_2099};
            sb.check_date(got);
         end
      end
   end

   initial begin
      #2000000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin
      sb = new();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Field extremes, unit rollovers, leap days and both sides of the limit that raises the overflow flag.
      send_timestamp(0);
      send_timestamp(999);
      send_timestamp(1000);
      send_timestamp(59999);
      send_timestamp(3599999);
      send_timestamp(86399999);
      send_timestamp(86400000);
      send_timestamp(day_start_ms(1970, 2, 1) - 1);
      send_timestamp(day_start_ms(1972, 2, 29));
      send_timestamp(day_start_ms(1972, 3, 1) - 1);
      send_timestamp(day_start_ms(1972, 12, 31) + 86399999);
      send_timestamp(day_start_ms(1973, 1, 1));
      send_timestamp(day_start_ms(2000, 2, 29) + 43200000);
      send_timestamp(day_start_ms(2038, 1, 19) + 11647999);
      send_timestamp(MS_AT_2100 - 1);
      send_timestamp(MS_AT_2100);
      send_timestamp(day_start_ms(2100, 2, 29) + 12345);
      send_timestamp(day_start_ms(2101, 1, 1));
      send_timestamp(64'h2AA_AAAA_AAAA);
      send_timestamp(64'h155_5555_5555);
      send_timestamp(TS_MAX);

      // Hold the sender until the pipeline has fully drained once.
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);

      // Random part, with occasional calm stretches where neither side idles.
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 50 == 0) begin
            calm = ($urandom_range(0, 3) == 0);
         end
         send_timestamp(random_timestamp());
      end
      calm = 1'b0;
      req_valid <= 1'b0;

      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
